// ----- src/uhid_pkg.sv -----
// ============================================================================
// uhid_pkg
// Shared types and constants for the USB HID class request decoder.
// ============================================================================
package uhid_pkg;

    // Event codes carried in the op field
    localparam logic [1:0] OP_SETUP    = 2'd0;
    localparam logic [1:0] OP_CONFIG   = 2'd1;
    localparam logic [1:0] OP_DATA     = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    // bmRequestType fields
    localparam logic [4:0] RECIP_IFACE    = 5'h01;
    localparam logic [1:0] TYPE_CLASS     = 2'b01;
    localparam logic [7:0] RT_STD_IN_IFACE = 8'h81;

    // Standard and class request codes
    localparam logic [7:0] REQ_GET_DESC      = 8'd6;
    localparam logic [7:0] HREQ_GET_REPORT   = 8'd1;
    localparam logic [7:0] HREQ_GET_IDLE     = 8'd2;
    localparam logic [7:0] HREQ_GET_PROTOCOL = 8'd3;
    localparam logic [7:0] HREQ_SET_REPORT   = 8'd9;
    localparam logic [7:0] HREQ_SET_IDLE     = 8'd10;
    localparam logic [7:0] HREQ_SET_PROTOCOL = 8'd11;

    // Descriptor types
    localparam logic [7:0] DESC_HID    = 8'h21;
    localparam logic [7:0] DESC_REPORT = 8'h22;

    // Defaults restored by reset; idle rate and protocol also by configuration change
    localparam logic [7:0] IDLE_DEFAULT     = 8'd128;
    localparam logic [7:0] PROTOCOL_DEFAULT = 8'd1;
    localparam logic [7:0] HID_DESC_LEN_DEFAULT = 8'd9;

    // Data stage sources
    localparam logic [2:0] SRC_NONE     = 3'd0;
    localparam logic [2:0] SRC_HID_DESC = 3'd1;
    localparam logic [2:0] SRC_RPT_DESC = 3'd2;
    localparam logic [2:0] SRC_IDLE     = 3'd3;
    localparam logic [2:0] SRC_PROTOCOL = 3'd4;
    localparam logic [2:0] SRC_IN_BUF   = 3'd5;
    localparam logic [2:0] SRC_OUT_BUF  = 3'd6;

    // Application report requests
    localparam logic [1:0] RR_NONE    = 2'd0;
    localparam logic [1:0] RR_FETCH   = 2'd1;
    localparam logic [1:0] RR_DELIVER = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERFACE_NUMBER  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HID_DESC_LENGTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RPT_DESC_LENGTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_REPORT_ENABLE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_REPORT_ENABLE = 3'd4;
    localparam int unsigned CFG_DATA_W = 16;

    // Result queue sizing
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  request_type;
        logic [7:0]  request_code;
        logic [7:0]  value_high;
        logic [7:0]  value_low;
        logic [7:0]  index_low;
        logic [15:0] transfer_length;
        logic [15:0] in_report_length;
    } in_item_t;

    typedef struct packed {
        logic        handled;
        logic [2:0]  data_source;
        logic [15:0] data_length;
        logic [1:0]  report_request;
        logic [7:0]  report_type;
        logic [7:0]  report_id;
        logic [15:0] report_length;
        logic [7:0]  idle_rate_out;
        logic [7:0]  protocol_out;
    } out_item_t;

    typedef struct packed {
        logic [7:0]  interface_number;
        logic [7:0]  hid_descriptor_length;
        logic [15:0] report_descriptor_length;
        logic        in_report_enabled;
        logic        out_report_enabled;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  idle_rate;
        logic [7:0]  protocol_mode;
        logic        set_report_pending;
        logic [7:0]  saved_report_type;
        logic [7:0]  saved_report_id;
        logic [15:0] saved_report_length;
    } hid_state_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count_next;
    } q_status_t;

endpackage

// ----- src/uhid_decode.sv -----
// ============================================================================
// uhid_decode
// Request decode logic and the HID function state it updates.
// ============================================================================
module uhid_decode
    import uhid_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fire,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t result
);

    hid_state_t st_reg;
    hid_state_t st_next;

    logic        recip_ok;
    logic        std_get_desc;
    logic        dir_in;
    logic        is_class;
    logic [15:0] hid_len_ext;

    assign dir_in      = item.request_type[7];
    assign is_class    = (item.request_type[6:5] == TYPE_CLASS);
    assign recip_ok    = (item.request_type[4:0] == RECIP_IFACE) &&
                         (item.index_low == cfg.interface_number);
    assign std_get_desc = (item.request_type == RT_STD_IN_IFACE) &&
                          (item.request_code == REQ_GET_DESC);
    assign hid_len_ext = {8'd0, cfg.hid_descriptor_length};

    // Decode one item against the current state
    always_comb
    begin
        st_next = st_reg;
        result  = '0;
        unique case (item.op)
            OP_SETUP:
            begin
                // a new setup aborts any pending report transfer
                st_next.set_report_pending = 1'b0;
                if (recip_ok)
                begin
                    priority if (std_get_desc && item.value_high == DESC_HID)
                    begin
                        result.handled     = 1'b1;
                        result.data_source = SRC_HID_DESC;
                        result.data_length = (hid_len_ext > item.transfer_length) ?
                                             item.transfer_length : hid_len_ext;
                    end
                    else if (std_get_desc && item.value_high == DESC_REPORT)
                    begin
                        result.handled     = 1'b1;
                        result.data_source = SRC_RPT_DESC;
                        result.data_length =
                            (cfg.report_descriptor_length > item.transfer_length) ?
                            item.transfer_length : cfg.report_descriptor_length;
                    end
                    else if (is_class)
                    begin
                        unique case (item.request_code)
                            HREQ_GET_IDLE:
                            begin
                                if (dir_in)
                                begin
                                    result.handled     = 1'b1;
                                    result.data_source = SRC_IDLE;
                                    result.data_length = 16'd1;
                                end
                            end
                            HREQ_SET_IDLE:
                            begin
                                if (!dir_in)
                                begin
                                    result.handled    = 1'b1;
                                    st_next.idle_rate = item.value_high;
                                end
                            end
                            HREQ_GET_PROTOCOL:
                            begin
                                if (dir_in)
                                begin
                                    result.handled     = 1'b1;
                                    result.data_source = SRC_PROTOCOL;
                                    result.data_length = 16'd1;
                                end
                            end
                            HREQ_SET_PROTOCOL:
                            begin
                                if (!dir_in)
                                begin
                                    result.handled        = 1'b1;
                                    st_next.protocol_mode = item.value_low;
                                end
                            end
                            HREQ_GET_REPORT:
                            begin
                                if (dir_in && cfg.in_report_enabled)
                                begin
                                    result.handled        = 1'b1;
                                    result.data_source    = SRC_IN_BUF;
                                    result.data_length    = item.in_report_length;
                                    result.report_request = RR_FETCH;
                                    result.report_type    = item.value_high;
                                    result.report_id      = item.value_low;
                                end
                            end
                            HREQ_SET_REPORT:
                            begin
                                if (!dir_in && cfg.out_report_enabled)
                                begin
                                    result.handled              = 1'b1;
                                    result.data_source          = SRC_OUT_BUF;
                                    result.data_length          = item.transfer_length;
                                    st_next.set_report_pending  = 1'b1;
                                    st_next.saved_report_type   = item.value_high;
                                    st_next.saved_report_id     = item.value_low;
                                    st_next.saved_report_length = item.transfer_length;
                                end
                            end
                            default:
                            begin
                                result.handled = 1'b0;
                            end
                        endcase
                    end
                    else
                    begin
                        result.handled = 1'b0;
                    end
                end
            end
            OP_CONFIG:
            begin
                // configuration change restores the idle rate and protocol defaults
                st_next.protocol_mode = PROTOCOL_DEFAULT;
                st_next.idle_rate     = IDLE_DEFAULT;
                result.handled        = 1'b1;
            end
            OP_DATA:
            begin
                // deliver the report armed by the last SET_REPORT
                if (st_reg.set_report_pending)
                begin
                    st_next.set_report_pending = 1'b0;
                    if (cfg.out_report_enabled)
                    begin
                        result.handled        = 1'b1;
                        result.report_request = RR_DELIVER;
                        result.report_type    = st_reg.saved_report_type;
                        result.report_id      = st_reg.saved_report_id;
                        result.report_length  = st_reg.saved_report_length;
                    end
                end
            end
            default:
            begin
                result.handled = 1'b0;
            end
        endcase
        result.idle_rate_out = st_next.idle_rate;
        result.protocol_out  = st_next.protocol_mode;
    end

    // Commit state when an item passes through
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.idle_rate           <= IDLE_DEFAULT;
            st_reg.protocol_mode       <= PROTOCOL_DEFAULT;
            st_reg.set_report_pending  <= 1'b0;
            st_reg.saved_report_type   <= '0;
            st_reg.saved_report_id     <= '0;
            st_reg.saved_report_length <= '0;
        end
        else if (fire)
        begin
            st_reg <= st_next;
        end
    end

endmodule

// ----- src/uhid_out_queue.sv -----
// ============================================================================
// uhid_out_queue
// Small result queue that decouples the decoder from the output stall.
// ============================================================================
module uhid_out_queue
    import uhid_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  out_item_t push_item,
    input  logic      out_stall,
    output logic      out_valid,
    output out_item_t out_data,
    output q_status_t status
);

    out_item_t         slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign pop       = out_valid && !out_stall;

    // Track fill level
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (!push && pop)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    assign status.count_next = count_next;

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    // Hold result payloads
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- src/usb_hid_class_request_decoder.sv -----
// ============================================================================
// usb_hid_class_request_decoder
// HID class request decoder for one interface: setup, config change, OUT done.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one event item:
//   a setup packet, a configuration change or an OUT data completion.
//   Output channel (out_valid / out_stall / out_data) returns exactly one
//   result item per input item, in order.
//   Configuration port (cfg_valid / cfg_ready / cfg_index / cfg_data) is
//   always ready; write it only while no items are in flight.
// Timing:
//   An accepted item lands in the input register, is decoded in the next
//   cycle and written to the result queue, whose head drives out_data.
//   One item per cycle is sustained while the output is not stalled;
//   the single decode pass sets this rate.
// Stall:
//   A four-entry result queue absorbs output stall. in_stall is registered
//   and rises once the input register plus queue hold four items.
// Reset:
//   Clears the queue, restores idle rate 128, protocol 1, no pending report,
//   and the configuration register reset values.
// ============================================================================
module usb_hid_class_request_decoder
    import uhid_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t        cfg_reg;
    logic        stage_valid_reg;
    in_item_t    stage_item_reg;
    logic        in_stall_reg;
    logic        in_stall_next;
    logic        accept;
    logic [QCNT_W:0] occ_next;
    out_item_t   result;
    q_status_t   q_status;

    assign accept    = in_valid && !in_stall_reg;
    assign in_stall  = in_stall_reg;
    assign cfg_ready = 1'b1;

    // Stall when the input register plus queue will be full
    assign occ_next      = {1'b0, q_status.count_next} + {{QCNT_W{1'b0}}, accept};
    assign in_stall_next = (occ_next >= (QCNT_W + 1)'(QDEPTH));

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            in_stall_reg    <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= accept;
            in_stall_reg    <= in_stall_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_item_reg <= in_data;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.interface_number         <= '0;
            cfg_reg.hid_descriptor_length    <= HID_DESC_LEN_DEFAULT;
            cfg_reg.report_descriptor_length <= '0;
            cfg_reg.in_report_enabled        <= 1'b0;
            cfg_reg.out_report_enabled       <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_INTERFACE_NUMBER:  cfg_reg.interface_number <= cfg_data[7:0];
                CFG_HID_DESC_LENGTH:   cfg_reg.hid_descriptor_length <= cfg_data[7:0];
                CFG_RPT_DESC_LENGTH:   cfg_reg.report_descriptor_length <= cfg_data;
                CFG_IN_REPORT_ENABLE:  cfg_reg.in_report_enabled <= cfg_data[0];
                CFG_OUT_REPORT_ENABLE: cfg_reg.out_report_enabled <= cfg_data[0];
                default:               cfg_reg <= cfg_reg;
            endcase
        end
    end

    uhid_decode u_decode (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (stage_valid_reg),
        .item   (stage_item_reg),
        .cfg    (cfg_reg),
        .result (result)
    );

    uhid_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (stage_valid_reg),
        .push_item (result),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .status    (q_status)
    );

endmodule

// ----- src/uhid_checker.sv -----
// ============================================================================
// uhid_checker
// Port-level checks on the HID request decoder's result channel.
// ============================================================================
module uhid_checker
    import uhid_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_data
);

    // Hold a stalled result item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result item changed");

    // Drop the data source, data length, report request and report length on an unhandled request
    a_unhandled_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.handled |->
            out_data.data_source == SRC_NONE && out_data.data_length == 16'd0 &&
            out_data.report_request == RR_NONE && out_data.report_length == 16'd0)
        else $error("unhandled result carries data");

    // Deliver a report only as a handled item with no data stage
    a_deliver_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.report_request == RR_DELIVER |->
            out_data.handled && out_data.data_source == SRC_NONE)
        else $error("bad report delivery item");

    // Idle and protocol reads are one byte
    a_one_byte_reads: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.data_source == SRC_IDLE ||
                      out_data.data_source == SRC_PROTOCOL) |->
            out_data.data_length == 16'd1 && out_data.handled)
        else $error("idle or protocol read length wrong");

endmodule

bind usb_hid_class_request_decoder uhid_checker u_checker (.*);
